// ----- hw/rtl/lds_pkg.sv -----
// Shared types and constants for the LPC solver.
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

  localparam int CORR_W     = 32;
  localparam int OUT_W      = 32;
  localparam int IDX_W      = 5;
  localparam int ORDER_W    = 5;
  localparam int FLOOR_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_RST = 5'd16;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 16'd2;

  localparam logic signed [31:0] Q31_MAX    = 32'sh7fff_ffff;
  localparam logic signed [31:0] LEAD_COEFF = 32'sh0800_0000;

  // shared multiplier: 32-bit magnitude times 64-bit magnitude, two passes
  localparam int MUL_X_W   = 32;
  localparam int MUL_Y_W   = 64;
  localparam int MUL_P_W   = 96;
  localparam int MUL_RES_W = 58;
  localparam logic [56:0] PROD_CAP = 57'h100000000000000;

  typedef struct packed {
    logic signed [CORR_W-1:0] corr_value;
    logic                     last_value;
  } lds_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] coeff;
    logic [IDX_W-1:0]        coeff_index;
    logic                    last_coeff;
    logic                    floored;
    logic                    saturated;
  } lds_out_t;

  typedef struct packed {
    logic [MUL_X_W-1:0] x;
    logic [MUL_Y_W-1:0] y;
    logic               neg;
    logic               sel31;
  } lds_mul_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [MUL_RES_W-1:0] value;
  } lds_mul_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lds_mul.sv -----
// Shared rounding multiplier: |x|*|y| / 2^s, half away from zero, capped at 2^56.
`timescale 1ns / 1ps
`default_nettype none
module lds_mul #(
  parameter int FRAC_BITS = 27
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire lds_pkg::lds_mul_req_t req_i,
  output lds_pkg::lds_mul_rsp_t      rsp_o
);
  import lds_pkg::*;

  typedef enum logic [2:0] {M_IDLE, M_P1, M_P2, M_P3, M_P4} mph_e;

  localparam logic [MUL_P_W-1:0] RND_FRAC = MUL_P_W'(1) << (FRAC_BITS - 1);
  localparam logic [MUL_P_W-1:0] RND_31   = MUL_P_W'(1) << 30;

  mph_e                        ph_q;
  logic [MUL_X_W-1:0]          x_q;
  logic [MUL_Y_W-1:0]          y_q;
  logic                        neg_q;
  logic                        sel_q;
  logic [63:0]                 prod_q;
  logic [MUL_P_W-1:0]          acc_q;
  logic signed [MUL_RES_W-1:0] res_q;
  logic                        done_q;

  logic [MUL_P_W-1:0] shifted;
  logic [56:0]        mag;
  logic [MUL_RES_W-1:0] mag_ext;

  always_comb begin
    shifted = sel_q ? (acc_q >> 31) : (acc_q >> FRAC_BITS);
    mag     = (shifted > MUL_P_W'(PROD_CAP)) ? PROD_CAP : shifted[56:0];
    mag_ext = {1'b0, mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= M_IDLE;
      done_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      neg_q  <= 1'b0;
      sel_q  <= 1'b0;
      prod_q <= '0;
      acc_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        M_IDLE: begin
          if (start_i) begin
            x_q   <= req_i.x;
            y_q   <= req_i.y;
            neg_q <= req_i.neg;
            sel_q <= req_i.sel31;
            ph_q  <= M_P1;
          end
        end
        M_P1: begin
          prod_q <= 64'(x_q) * 64'(y_q[31:0]);
          ph_q   <= M_P2;
        end
        M_P2: begin
          acc_q  <= MUL_P_W'(prod_q) + (sel_q ? RND_31 : RND_FRAC);
          prod_q <= 64'(x_q) * 64'(y_q[63:32]);
          ph_q   <= M_P3;
        end
        M_P3: begin
          acc_q <= acc_q + {prod_q, 32'b0};
          ph_q  <= M_P4;
        end
        M_P4: begin
          res_q  <= neg_q ? -$signed(mag_ext) : $signed(mag_ext);
          done_q <= 1'b1;
          ph_q   <= M_IDLE;
        end
        default: ph_q <= M_IDLE;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lds_div.sv -----
// Restoring divider, one quotient bit per cycle: floor(num * 2^31 / den), num < den.
`timescale 1ns / 1ps
`default_nettype none
module lds_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] num_i,
  input  wire logic [30:0] den_i,
  output logic             done_o,
  output logic [30:0]      quo_o
);

  localparam logic [4:0] LAST_STEP = 5'd30;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [30:0] den_q;
  logic [30:0] quo_q;

  logic [31:0] rem2;
  logic        ge;

  always_comb begin
    rem2 = {rem_q[30:0], 1'b0};
    ge   = rem2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
          rem_q  <= {1'b0, num_i};
          den_q  <= den_i;
        end
      end else begin
        rem_q <= ge ? (rem2 - {1'b0, den_q}) : rem2;
        quo_q <= {quo_q[29:0], ge};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- hw/rtl/levinson_durbin_lpc_solver_unit.sv -----
// LPC solver top level: lag store, coefficient store and the recursion sequencer.
// Each lag request is taken while in_stall_o is low; the lag that ends a frame starts the solve.
// Each stage uses the shared multiplier and, unless k clips, the divider; once the recursion
// ends, every coefficient is checked for output clipping before the first result leaves.
// Results leave one at a time; no new lag is taken until the last one leaves.
// Async reset clears control, lag valid bits and config (order 16, floor 2); no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module levinson_durbin_lpc_solver_unit #(
  parameter int MAX_ORDER   = 16,
  parameter int COEFF_WIDTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire lds_pkg::lds_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output lds_pkg::lds_out_t                     out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import lds_pkg::*;

  localparam int DEPTH     = MAX_ORDER + 1;
  localparam int AW        = $clog2(DEPTH);
  localparam int LW        = $clog2(DEPTH + 1);
  localparam int FRAC_BITS = COEFF_WIDTH - 5;

  localparam logic signed [63:0] CF_HI  = (64'sd1 <<< (COEFF_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] CF_LO  = -CF_HI - 64'sd1;
  localparam logic signed [63:0] OUT_HI = 64'sd2147483647;
  localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;
  localparam logic signed [COEFF_WIDTH-1:0] CF_ONE = COEFF_WIDTH'(64'd1 << FRAC_BITS);

  // Q31 -> coefficient format
  localparam int SH_DN    = (FRAC_BITS < 31) ? 31 - FRAC_BITS : 0;
  localparam int SH_UP    = (FRAC_BITS > 31) ? FRAC_BITS - 31 : 0;
  localparam int SH_DN_M1 = (SH_DN > 0) ? SH_DN - 1 : 0;
  localparam logic [63:0] RND_DN = (SH_DN > 0) ? (64'd1 << SH_DN_M1) : 64'd0;
  // coefficient format -> Q4.27 output
  localparam int OUT_DN    = (COEFF_WIDTH > 32) ? COEFF_WIDTH - 32 : 0;
  localparam int OUT_UP    = (COEFF_WIDTH < 32) ? 32 - COEFF_WIDTH : 0;
  localparam int OUT_DN_M1 = (OUT_DN > 0) ? OUT_DN - 1 : 0;
  localparam logic [63:0] RND_OUT = (OUT_DN > 0) ? (64'd1 << OUT_DN_M1) : 64'd0;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_R0, S_SRD, S_SMUL, S_SWAIT, S_DIV, S_DWAIT,
    S_K2, S_K2W, S_SIG, S_SIGW, S_URD, S_UM1, S_UW1, S_UM2, S_UW2,
    S_KSET, S_CRD, S_CCHK, S_ORD, S_OLD, S_OWAIT
  } state_e;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] rshift_round(input logic signed [63:0] v,
                                                      input int sh,
                                                      input logic [63:0] rnd);
    logic [63:0] m;
    logic [63:0] r;
    m = abs64(v);
    r = (m + rnd) >> sh;
    rshift_round = v[63] ? -$signed(r) : $signed(r);
  endfunction

  // {clipped, value}
  function automatic logic [64:0] sat64(input logic signed [63:0] v,
                                        input logic signed [63:0] hi,
                                        input logic signed [63:0] lo);
    if (v > hi) begin
      sat64 = {1'b1, hi};
    end else if (v < lo) begin
      sat64 = {1'b1, lo};
    end else begin
      sat64 = {1'b0, v};
    end
  endfunction

  function automatic logic [64:0] k_to_cf(input logic signed [31:0] k);
    logic signed [63:0] v;
    v = rshift_round(64'(k), SH_DN, RND_DN) <<< SH_UP;
    k_to_cf = sat64(v, CF_HI, CF_LO);
  endfunction

  function automatic logic [64:0] cf_to_out(input logic signed [COEFF_WIDTH-1:0] a);
    logic signed [63:0] v;
    v = rshift_round(64'(a), OUT_DN, RND_OUT) <<< OUT_UP;
    cf_to_out = sat64(v, OUT_HI, OUT_LO);
  endfunction

  state_e                        st_q;
  logic [AW-1:0]                 i_q;
  logic [AW-1:0]                 j_q;
  logic [AW-1:0]                 ord_q;
  logic [AW-1:0]                 top_q;
  logic [LW-1:0]                 load_cnt_q;
  logic [DEPTH-1:0]              corr_vld_q;
  logic [ORDER_W-1:0]            order_q;
  logic [FLOOR_W-1:0]            floor_q;
  logic                          floored_q;
  logic                          sat_q;
  logic signed [31:0]            sigma_q;
  logic signed [63:0]            acc_q;
  logic signed [31:0]            k_q;
  logic [31:0]                   k2_q;
  logic signed [COEFF_WIDTH-1:0] aj_q;
  logic signed [COEFF_WIDTH-1:0] aij_q;
  logic                          out_valid_q;
  lds_out_t                      out_data_q;

  // lag and coefficient stores
  logic signed [31:0]            corr_mem [DEPTH];
  logic signed [COEFF_WIDTH-1:0] coef_mem [DEPTH];
  logic signed [31:0]            corr_rd_q;
  logic                          corr_rd_vld_q;
  logic signed [COEFF_WIDTH-1:0] cf_rd0_q;
  logic signed [COEFF_WIDTH-1:0] cf_rd1_q;

  logic [AW-1:0]                 diff;
  logic                          corr_we;
  logic                          cf_we;
  logic [AW-1:0]                 cf_wa;
  logic signed [COEFF_WIDTH-1:0] cf_wd;
  logic                          cf_wsat;
  logic signed [31:0]            corr_val;
  logic [AW-1:0]                 ord_clamp;

  lds_mul_req_t                  mul_req;
  lds_mul_rsp_t                  mul_rsp;
  logic                          mul_start;
  logic signed [MUL_RES_W-1:0]   mul_res;

  logic                          div_start;
  logic                          div_done;
  logic [30:0]                   div_quo;
  logic [63:0]                   acc_mag;
  logic                          k_clip;

  logic [64:0]                   upd_sat;
  logic [64:0]                   kcf_sat;
  logic [64:0]                   out_conv;

  assign diff     = i_q - j_q;
  assign corr_val = corr_rd_vld_q ? corr_rd_q : 32'sd0;
  assign mul_res  = mul_rsp.value;
  assign acc_mag  = abs64(acc_q);
  assign k_clip   = acc_mag >= {32'b0, sigma_q};
  assign corr_we  = (st_q == S_LOAD) && in_valid_i && (load_cnt_q <= LW'(MAX_ORDER));
  assign out_conv = cf_to_out(cf_rd0_q);

  always_comb begin
    if (order_q < ORDER_W'(2)) begin
      ord_clamp = AW'(2);
    end else if (int'(order_q) > MAX_ORDER) begin
      ord_clamp = AW'(MAX_ORDER);
    end else begin
      ord_clamp = AW'(order_q);
    end
  end

  // multiplier operand select
  always_comb begin
    mul_req   = '0;
    mul_start = 1'b0;
    case (st_q)
      S_SMUL: begin
        mul_start     = 1'b1;
        mul_req.x     = 32'(abs64(64'(corr_val)));
        mul_req.y     = abs64(64'(cf_rd0_q));
        mul_req.neg   = corr_val[31] ^ cf_rd0_q[COEFF_WIDTH-1];
        mul_req.sel31 = 1'b0;
      end
      S_K2: begin
        mul_start     = 1'b1;
        mul_req.x     = 32'(abs64(64'(k_q)));
        mul_req.y     = abs64(64'(k_q));
        mul_req.sel31 = 1'b1;
      end
      S_SIG: begin
        mul_start     = 1'b1;
        mul_req.x     = sigma_q;
        mul_req.y     = 64'h8000_0000 - 64'(k2_q);
        mul_req.sel31 = 1'b1;
      end
      S_UM1: begin
        mul_start     = 1'b1;
        mul_req.x     = 32'(abs64(64'(k_q)));
        mul_req.y     = abs64(64'(cf_rd1_q));
        mul_req.neg   = k_q[31] ^ cf_rd1_q[COEFF_WIDTH-1];
        mul_req.sel31 = 1'b1;
      end
      S_UM2: begin
        mul_start     = 1'b1;
        mul_req.x     = 32'(abs64(64'(k_q)));
        mul_req.y     = abs64(64'(aj_q));
        mul_req.neg   = k_q[31] ^ aj_q[COEFF_WIDTH-1];
        mul_req.sel31 = 1'b1;
      end
      default: ;
    endcase
  end

  assign div_start = (st_q == S_DIV) && !k_clip;

  // coefficient store write port
  always_comb begin
    upd_sat = sat64(64'((st_q == S_UW2) ? aij_q : aj_q) + 64'(mul_res), CF_HI, CF_LO);
    kcf_sat = k_to_cf(k_q);
    cf_we   = 1'b0;
    cf_wa   = j_q;
    cf_wd   = COEFF_WIDTH'(upd_sat[63:0]);
    cf_wsat = 1'b0;
    case (st_q)
      S_INIT: begin
        cf_we = 1'b1;
        cf_wa = '0;
        cf_wd = CF_ONE;
      end
      S_UW1: begin
        cf_we   = mul_rsp.done;
        cf_wsat = upd_sat[64];
      end
      S_UW2: begin
        cf_we   = mul_rsp.done;
        cf_wa   = diff;
        cf_wsat = upd_sat[64];
      end
      S_KSET: begin
        cf_we   = 1'b1;
        cf_wa   = i_q;
        cf_wd   = COEFF_WIDTH'(kcf_sat[63:0]);
        cf_wsat = kcf_sat[64];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    corr_rd_q     <= corr_mem[diff];
    corr_rd_vld_q <= corr_vld_q[diff];
    cf_rd0_q      <= coef_mem[j_q];
    cf_rd1_q      <= coef_mem[diff];
    if (corr_we) begin
      corr_mem[load_cnt_q[AW-1:0]] <= in_data_i.corr_value;
    end
    if (cf_we) begin
      coef_mem[cf_wa] <= cf_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_LOAD;
      i_q         <= '0;
      j_q         <= '0;
      ord_q       <= '0;
      top_q       <= '0;
      load_cnt_q  <= '0;
      corr_vld_q  <= '0;
      order_q     <= ORDER_RST;
      floor_q     <= FLOOR_RST;
      floored_q   <= 1'b0;
      sat_q       <= 1'b0;
      sigma_q     <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      k2_q        <= '0;
      aj_q        <= '0;
      aij_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORDER: order_q <= cfg_wdata_i[ORDER_W-1:0];
          REG_FLOOR: floor_q <= cfg_wdata_i[FLOOR_W-1:0];
          default: ;
        endcase
      end
      case (st_q)
        S_LOAD: begin
          if (in_valid_i) begin
            if (corr_we) begin
              corr_vld_q[load_cnt_q[AW-1:0]] <= 1'b1;
              load_cnt_q <= load_cnt_q + LW'(1);
            end
            if (in_data_i.last_value) begin
              ord_q     <= ord_clamp;
              i_q       <= '0;
              j_q       <= '0;
              floored_q <= 1'b0;
              sat_q     <= 1'b0;
              st_q      <= S_INIT;
            end
          end
        end
        S_INIT: begin
          top_q <= '0;
          st_q  <= S_R0;
        end
        S_R0: begin
          if (corr_val <= 32'sd0) begin
            floored_q <= 1'b1;
            j_q       <= '0;
            st_q      <= S_CRD;
          end else begin
            sigma_q <= corr_val;
            i_q     <= AW'(1);
            j_q     <= '0;
            acc_q   <= '0;
            st_q    <= S_SRD;
          end
        end
        S_SRD:  st_q <= S_SMUL;
        S_SMUL: st_q <= S_SWAIT;
        S_SWAIT: begin
          if (mul_rsp.done) begin
            acc_q <= acc_q + 64'(mul_res);
            if (j_q == i_q - AW'(1)) begin
              st_q <= S_DIV;
            end else begin
              j_q  <= j_q + AW'(1);
              st_q <= S_SRD;
            end
          end
        end
        S_DIV: begin
          if (k_clip) begin
            sat_q <= 1'b1;
            k_q   <= acc_q[63] ? Q31_MAX : -Q31_MAX;
            st_q  <= S_K2;
          end else begin
            st_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            k_q  <= acc_q[63] ? $signed({1'b0, div_quo}) : -$signed({1'b0, div_quo});
            st_q <= S_K2;
          end
        end
        S_K2: st_q <= S_K2W;
        S_K2W: begin
          if (mul_rsp.done) begin
            k2_q <= mul_res[31:0];
            st_q <= S_SIG;
          end
        end
        S_SIG: st_q <= S_SIGW;
        S_SIGW: begin
          if (mul_rsp.done) begin
            if (mul_res <= $signed(MUL_RES_W'(floor_q))) begin
              sigma_q   <= $signed(32'(floor_q));
              floored_q <= 1'b1;
              j_q       <= '0;
              st_q      <= S_CRD;
            end else begin
              sigma_q <= mul_res[31:0];
              if (i_q >= AW'(2)) begin
                j_q  <= AW'(1);
                st_q <= S_URD;
              end else begin
                st_q <= S_KSET;
              end
            end
          end
        end
        S_URD: st_q <= S_UM1;
        S_UM1: begin
          aj_q  <= cf_rd0_q;
          aij_q <= cf_rd1_q;
          st_q  <= S_UW1;
        end
        S_UW1, S_UW2: begin
          if (mul_rsp.done) begin
            sat_q <= sat_q | cf_wsat;
            if ((st_q == S_UW1) && (j_q != diff)) begin
              st_q <= S_UM2;
            end else if (j_q == (i_q >> 1)) begin
              st_q <= S_KSET;
            end else begin
              j_q  <= j_q + AW'(1);
              st_q <= S_URD;
            end
          end
        end
        S_UM2: st_q <= S_UW2;
        S_KSET: begin
          sat_q <= sat_q | cf_wsat;
          top_q <= i_q;
          j_q   <= '0;
          if (i_q == ord_q) begin
            st_q <= S_CRD;
          end else begin
            i_q   <= i_q + AW'(1);
            acc_q <= '0;
            st_q  <= S_SRD;
          end
        end
        // output conversion may clip; flags must be known before the first result
        S_CRD: st_q <= S_CCHK;
        S_CCHK: begin
          if (j_q <= top_q) begin
            sat_q <= sat_q | out_conv[64];
          end
          if (j_q == ord_q) begin
            j_q  <= '0;
            st_q <= S_ORD;
          end else begin
            j_q  <= j_q + AW'(1);
            st_q <= S_CRD;
          end
        end
        S_ORD: st_q <= S_OLD;
        S_OLD: begin
          out_data_q.coeff       <= (j_q <= top_q) ? OUT_W'(out_conv[63:0]) : '0;
          out_data_q.coeff_index <= IDX_W'(j_q);
          out_data_q.last_coeff  <= (j_q == ord_q);
          out_data_q.floored     <= floored_q;
          out_data_q.saturated   <= sat_q;
          out_valid_q            <= 1'b1;
          st_q                   <= S_OWAIT;
        end
        S_OWAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (j_q == ord_q) begin
              load_cnt_q <= '0;
              corr_vld_q <= '0;
              st_q       <= S_LOAD;
            end else begin
              j_q  <= j_q + AW'(1);
              st_q <= S_ORD;
            end
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  lds_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  lds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (acc_mag[30:0]),
    .den_i  (sigma_q[30:0]),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_stall_o  = (st_q != S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- hw/rtl/lds_chk.sv -----
// Port-level checks for the LPC solver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lds_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire lds_pkg::lds_out_t out_data_o
);
  import lds_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("taking lags while results are pending");

  a_lead_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.coeff_index == '0) |-> out_data_o.coeff == LEAD_COEFF)
    else $error("leading coefficient is not one");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_coeff |=> !out_valid_o)
    else $error("result after end of frame");

endmodule

bind levinson_durbin_lpc_solver_unit lds_chk u_lds_chk (.*);
`default_nettype wire
